[rtl/epq_pkg.sv]
// shared constants, types and codes for the event priority queue
`default_nettype none

package epq_pkg;

  localparam int CAPACITY   = 16;
  localparam int ID_BITS    = 16;
  localparam int TIME_BITS  = 32;
  localparam int DATA_BITS  = 32;
  localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int OP_BITS    = 3;
  localparam int ST_BITS    = 3;
  localparam int ENTRY_BITS = ID_BITS + TIME_BITS + DATA_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_POP    = 3'd2,
    OP_PEEK   = 3'd3,
    OP_UPDATE = 3'd4
  } op_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } epq_state_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] tm;
    logic [DATA_BITS-1:0] dt;
  } slot_entry_t;

endpackage

`default_nettype wire

[rtl/epq_if.sv]
// valid/ready channel interfaces for operations and results
`default_nettype none

interface epq_in_if;
  logic                           valid;
  logic                           ready;
  logic [epq_pkg::OP_BITS-1:0]    opcode;
  logic [epq_pkg::ID_BITS-1:0]    event_id;
  logic [epq_pkg::TIME_BITS-1:0]  event_time;
  logic [epq_pkg::DATA_BITS-1:0]  event_data;

  modport source (output valid, opcode, event_id, event_time, event_data, input ready);
  modport sink   (input valid, opcode, event_id, event_time, event_data, output ready);
endinterface

interface epq_out_if;
  logic                            valid;
  logic                            ready;
  logic [epq_pkg::ST_BITS-1:0]     status;
  logic [epq_pkg::ID_BITS-1:0]     out_id;
  logic [epq_pkg::TIME_BITS-1:0]   out_time;
  logic [epq_pkg::DATA_BITS-1:0]   out_data;
  logic [epq_pkg::COUNT_BITS-1:0]  occupancy;

  modport source (output valid, status, out_id, out_time, out_data, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_time, out_data, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/event_priority_queue_top.sv]
// event priority queue: memory-held slots scanned once per operation
// the result is loaded into the output register when the decision fires in the done state
// a new operation is taken only in idle, after the last one has been decided; the scan
//   reads one slot per cycle through the single read port of the slot ram
// a finished result waits in the output register while the next operation is taken
// reset (synchronous, active low) clears all slot valid bits, the count and the fsm;
//   slot ram contents are not cleared and are only read behind a valid bit
`default_nettype none

module event_priority_queue_top (
  input wire logic  clk,
  input wire logic  rst_n,
  epq_in_if.sink    in_ch,
  epq_out_if.source out_ch
);

  import epq_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(CAPACITY - 1);

  epq_state_t state_r, state_nxt;

  // operation latched at input transfer
  logic [OP_BITS-1:0]   op_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] tm_r;
  logic [DATA_BITS-1:0] dt_r;

  // slot bookkeeping in flops
  logic [CAPACITY-1:0]   valid_r;
  logic [COUNT_BITS-1:0] count_r;

  // scan address and the read pipeline registers beside the ram
  logic [SLOT_BITS-1:0] addr_r;
  logic                 pipe_v_r;
  logic [SLOT_BITS-1:0] pipe_idx_r;
  logic                 pipe_slot_v_r;

  // scan results
  logic                 hit_r;
  logic [SLOT_BITS-1:0] hit_idx_r;
  slot_entry_t          hit_entry_r;
  logic                 best_v_r;
  logic [SLOT_BITS-1:0] best_idx_r;
  slot_entry_t          best_entry_r;
  logic                 free_v_r;
  logic [SLOT_BITS-1:0] free_idx_r;

  // output register
  logic                  out_valid_r;
  logic [ST_BITS-1:0]    out_status_r;
  slot_entry_t           out_entry_r;
  logic [COUNT_BITS-1:0] out_count_r;

  // ram ports
  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  slot_entry_t           ram_wdata;
  logic [ENTRY_BITS-1:0] ram_rdata;
  slot_entry_t           rd_entry;

  // decision made in the done state
  logic                  in_xfer;
  logic                  done_fire;
  logic [ST_BITS-1:0]    res_status;
  slot_entry_t           res_entry;
  logic                  set_valid;
  logic                  clr_valid;
  logic [SLOT_BITS-1:0]  clr_idx;
  logic [COUNT_BITS-1:0] count_after;

  epq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_entry = slot_entry_t'(ram_rdata);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // the result may only be committed when the output register is free
  assign done_fire   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_id    = out_entry_r.id;
  assign out_ch.out_time  = out_entry_r.tm;
  assign out_ch.out_data  = out_entry_r.dt;
  assign out_ch.occupancy = out_count_r;

  // fsm: idle -> scan every slot -> drain the last read -> decide and write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (addr_r == LAST_SLOT) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // operation decision; writes happen only here, after the scan has finished,
  // so no read of the next scan can overlap a pending write
  always_comb begin
    res_status = ST_OK;
    res_entry  = '0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx_r;
    ram_wdata  = '{id: id_r, tm: tm_r, dt: dt_r};
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    clr_idx    = hit_idx_r;
    case (op_r)
      OP_ADD: begin
        if (hit_r) begin
          res_status = ST_DUP;
          res_entry  = hit_entry_r;
        end else begin
          res_entry = '{id: id_r, tm: tm_r, dt: dt_r};
          if (!free_v_r) begin
            res_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            set_valid = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_r) begin
          res_entry = hit_entry_r;
          clr_valid = 1'b1;
        end else begin
          res_status   = ST_NOTFOUND;
          res_entry.id = id_r;
        end
      end
      OP_UPDATE: begin
        if (hit_r) begin
          res_entry = '{id: hit_entry_r.id, tm: tm_r, dt: dt_r};
          ram_we    = 1'b1;
          ram_waddr = hit_idx_r;
          ram_wdata = res_entry;
        end else begin
          res_status   = ST_NOTFOUND;
          res_entry.id = id_r;
        end
      end
      OP_POP, OP_PEEK: begin
        if (best_v_r) begin
          res_entry = best_entry_r;
          if (op_r == OP_POP) begin
            clr_valid = 1'b1;
            clr_idx   = best_idx_r;
          end
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        // undefined opcode: no operation
        res_status = ST_OK;
      end
    endcase
    if (!done_fire) begin
      ram_we    = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
    end
    count_after = count_r + COUNT_BITS'(set_valid) - COUNT_BITS'(clr_valid);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pipe_v_r    <= 1'b0;
    end else begin
      pipe_v_r <= (state_r == S_SCAN);
      if (set_valid) valid_r[free_idx_r] <= 1'b1;
      if (clr_valid) valid_r[clr_idx] <= 1'b0;
      count_r <= count_after;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: operation capture, scan address, compare against each read slot
  always_ff @(posedge clk) begin
    pipe_idx_r    <= addr_r;
    pipe_slot_v_r <= valid_r[addr_r];
    if (in_xfer) begin
      op_r     <= in_ch.opcode;
      id_r     <= in_ch.event_id;
      tm_r     <= in_ch.event_time;
      dt_r     <= in_ch.event_data;
      addr_r   <= '0;
      hit_r    <= 1'b0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
    end else begin
      if (state_r == S_SCAN && addr_r != LAST_SLOT) begin
        addr_r <= addr_r + SLOT_BITS'(1);
      end
      if (pipe_v_r) begin
        if (pipe_slot_v_r) begin
          if (rd_entry.id == id_r) begin
            hit_r       <= 1'b1;
            hit_idx_r   <= pipe_idx_r;
            hit_entry_r <= rd_entry;
          end
          // earliest time, ties to the lower id
          if (!best_v_r || rd_entry.tm < best_entry_r.tm ||
              (rd_entry.tm == best_entry_r.tm && rd_entry.id < best_entry_r.id)) begin
            best_v_r     <= 1'b1;
            best_idx_r   <= pipe_idx_r;
            best_entry_r <= rd_entry;
          end
        end else if (!free_v_r) begin
          // lowest free slot
          free_v_r   <= 1'b1;
          free_idx_r <= pipe_idx_r;
        end
      end
    end
    if (done_fire) begin
      out_status_r <= res_status;
      out_entry_r  <= res_entry;
      out_count_r  <= count_after;
    end
  end

  // the count always tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("held count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("held count above capacity");

  a_xfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SCAN) && (addr_r == '0))
    else $error("input transfer did not start a scan from slot zero");

  a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DONE) && !pipe_v_r)
    else $error("slot ram written while a scan is in flight");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("decision did not load the output register");

endmodule

`default_nettype wire

[rtl/epq_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module epq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[dv/event_priority_queue_top_tb.sv]
// self-checking testbench for the event priority queue: directed, fill/drain and random traffic
`timescale 1ns / 1ps

module event_priority_queue_top_tb;
  import epq_pkg::*;

  // opcodes with no meaning, still answered with a status ok result
  localparam logic [OP_BITS-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_BITS-1:0] OP_LAST         = 3'd7;

  // worst case is far below this: ~450 ops plus sender gaps,
  // receiver stalls and the long hold-off
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // extra wait at the end, after every owed result has come back
  localparam int SETTLE_CYCLES = 2 * (CAPACITY + 2);

  typedef struct {
    status_t               status;
    logic [ID_BITS-1:0]    id;
    logic [TIME_BITS-1:0]  tm;
    logic [DATA_BITS-1:0]  dt;
    logic [COUNT_BITS-1:0] occ;
  } outcome_t;

  logic clk;
  logic rst_n;

  epq_in_if  in_ch();
  epq_out_if out_ch();

  event_priority_queue_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // testbench copy of the queue contents
  logic                  model_valid [CAPACITY];
  logic [ID_BITS-1:0]    model_id    [CAPACITY];
  logic [TIME_BITS-1:0]  model_time  [CAPACITY];
  logic [DATA_BITS-1:0]  model_data  [CAPACITY];
  logic [COUNT_BITS-1:0] model_count;

  // results still owed by the block, oldest first
  outcome_t expected_outcomes[$];

  int      error_count = 0;
  int      cycle_count = 0;
  int      burst_left  = 0;
  bit      steady_send = 0;   // suppresses sender gaps while the receiver holds off
  int      hold_seq    = 0;   // bumped by the stimulus to request a long receiver hold
  int      hold_seen   = 0;
  int      hold_left   = 0;
  int      stall_mode  = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // reference behavior
  // ---------------------------------------------------------------------------

  function automatic int locate_id(input logic [ID_BITS-1:0] id);
    for (int i = 0; i < CAPACITY; i++)
      if (model_valid[i] && model_id[i] == id) return i;
    return -1;
  endfunction

  // earliest time wins, equal times go to the lower id
  function automatic int locate_earliest();
    int best;
    best = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!model_valid[i]) continue;
      if (best < 0 || model_time[i] < model_time[best] ||
          (model_time[i] == model_time[best] && model_id[i] < model_id[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic int locate_free();
    for (int i = 0; i < CAPACITY; i++)
      if (!model_valid[i]) return i;
    return -1;
  endfunction

  // applies one accepted operation to the model and queues the result it owes
  task automatic apply_to_model(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                                input logic [TIME_BITS-1:0] tm,
                                input logic [DATA_BITS-1:0] dt);
    outcome_t res;
    int       k;
    res.status = ST_OK;
    res.id     = '0;
    res.tm     = '0;
    res.dt     = '0;
    case (op)
      OP_ADD: begin
        k = locate_id(id);
        if (k >= 0) begin
          // duplicate: report what is already stored
          res.status = ST_DUP;
          res.id     = model_id[k];
          res.tm     = model_time[k];
          res.dt     = model_data[k];
        end else begin
          res.id = id;
          res.tm = tm;
          res.dt = dt;
          k = locate_free();
          if (k < 0) begin
            res.status = ST_FULL;
          end else begin
            model_valid[k] = 1'b1;
            model_id[k]    = id;
            model_time[k]  = tm;
            model_data[k]  = dt;
            model_count++;
          end
        end
      end
      OP_REMOVE, OP_UPDATE: begin
        k = locate_id(id);
        if (k < 0) begin
          res.status = ST_NOTFOUND;
          res.id     = id;
        end else begin
          if (op == OP_UPDATE) begin
            model_time[k] = tm;
            model_data[k] = dt;
          end
          res.id = model_id[k];
          res.tm = model_time[k];
          res.dt = model_data[k];
          if (op == OP_REMOVE) begin
            model_valid[k] = 1'b0;
            model_count--;
          end
        end
      end
      OP_POP, OP_PEEK: begin
        k = locate_earliest();
        if (k < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.id = model_id[k];
          res.tm = model_time[k];
          res.dt = model_data[k];
          if (op == OP_POP) begin
            model_valid[k] = 1'b0;
            model_count--;
          end
        end
      end
      default: ;  // unused opcode, no change
    endcase
    res.occ = model_count;
    expected_outcomes.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the edge where the transfer happened,
  // with valid still high so a following item goes out back to back
  task automatic send_op(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                         input logic [TIME_BITS-1:0] tm, input logic [DATA_BITS-1:0] dt);
    int gap;
    if (burst_left == 0 && !steady_send) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.event_id   <= id;
    in_ch.event_time <= tm;
    in_ch.event_data <= dt;
    do @(posedge clk); while (!in_ch.ready);
    apply_to_model(op, id, tm, dt);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // mostly ids already stored (live_pct percent) or a small pool so ids collide,
  // the rest the full 16-bit range
  function automatic logic [ID_BITS-1:0] pick_event_id(input int live_pct);
    int k;
    if (model_count != 0 && $urandom_range(0, 99) < live_pct) begin
      do k = $urandom_range(0, CAPACITY - 1); while (!model_valid[k]);
      return model_id[k];
    end
    if ($urandom_range(0, 1) == 0) return ID_BITS'($urandom_range(0, 63));
    return ID_BITS'($urandom());
  endfunction

  // small times give plenty of ties, extremes hit the range limits
  function automatic logic [TIME_BITS-1:0] pick_event_time();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return TIME_BITS'($urandom_range(0, 7));
    if (r == 4) return '0;
    if (r == 5) return '1;
    return TIME_BITS'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 100)
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // receiver ready: a long hold when asked, otherwise a stall pattern that
  // is redrawn at random (always ready, coin flip, fixed duty)
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (cycle_count % 200 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (cycle_count % 7) < 3;
      endcase
    end
  end

  // compare every result transfer against the oldest owed result
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending, status", 64'(out_ch.status), 64'(0));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
        if (out_ch.out_id !== want.id)
          report_mismatch("out_id", 64'(out_ch.out_id), 64'(want.id));
        if (out_ch.out_time !== want.tm)
          report_mismatch("out_time", 64'(out_ch.out_time), 64'(want.tm));
        if (out_ch.out_data !== want.dt)
          report_mismatch("out_data", 64'(out_ch.out_data), 64'(want.dt));
        if (out_ch.occupancy !== want.occ)
          report_mismatch("occupancy", 64'(out_ch.occupancy), 64'(want.occ));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty queue answers, unknown ids, unused opcodes, field extremes,
  // duplicate add, update and tie on time resolved by the lower id
  task automatic test_directed();
    send_op(OP_PEEK,   16'h1234, '0, '0);
    send_op(OP_POP,    16'h1234, '0, '0);
    send_op(OP_REMOVE, 16'h0005, '0, '0);
    send_op(OP_UPDATE, 16'h0006, 32'h11, 32'h22);
    send_op(OP_FIRST_UNUSED,     16'hffff, '1, '1);
    send_op(OP_BITS'(OP_FIRST_UNUSED + 1), 16'h0001, 32'h5, 32'h6);
    send_op(OP_LAST,             16'h0000, '0, '0);
    send_op(OP_ADD,    16'h0000, '1, '0);
    send_op(OP_ADD,    16'hffff, '0, '1);
    send_op(OP_ADD,    16'h0000, 32'h1, 32'h2);      // duplicate id
    send_op(OP_PEEK,   16'h0000, '0, '0);
    send_op(OP_UPDATE, 16'hffff, '1, 32'h5a5a_a5a5); // now tied on time with id 0
    send_op(OP_PEEK,   16'h0000, '0, '0);
    send_op(OP_REMOVE, 16'h0000, '0, '0);
    send_op(OP_REMOVE, 16'h0000, '0, '0);            // already gone
    send_op(OP_POP,    16'h0000, '0, '0);
    send_op(OP_POP,    16'h0000, '0, '0);            // empty again
  endtask

  // fill to capacity, hit the full and duplicate-while-full cases, then drain
  // in priority order down to an empty pop
  task automatic test_fill_and_drain();
    logic [ID_BITS-1:0] id;
    while (model_count < CAPACITY)
      send_op(OP_ADD, pick_event_id(10), TIME_BITS'($urandom_range(0, 5)), $urandom());
    do id = pick_event_id(0); while (locate_id(id) >= 0);
    send_op(OP_ADD, id, pick_event_time(), $urandom());
    send_op(OP_ADD, pick_event_id(100), pick_event_time(), $urandom());
    send_op(OP_UPDATE, pick_event_id(100), TIME_BITS'($urandom_range(0, 5)), $urandom());
    send_op(OP_PEEK, '0, '0, '0);
    while (model_count != 0) send_op(OP_POP, pick_event_id(0), '0, '0);
    send_op(OP_POP, '0, '0, '0);
  endtask

  // random mix in phases that lean toward filling or toward draining
  task automatic test_random_mix(input int n_items);
    logic [OP_BITS-1:0] op;
    int                 r;
    bit                 filling;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) filling = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 4)                          op = OP_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST));
      else if (r < (filling ? 60 : 30))   op = OP_ADD;
      else if (r < (filling ? 70 : 50))   op = OP_REMOVE;
      else if (r < (filling ? 80 : 75))   op = OP_POP;
      else if (r < (filling ? 88 : 85))   op = OP_PEEK;
      else                                op = OP_UPDATE;
      send_op(op, pick_event_id(op == OP_ADD ? 25 : 70), pick_event_time(), $urandom());
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the result register fills and the input stalls
  task automatic test_output_backpressure();
    steady_send = 1'b1;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 12; i++)
      send_op(i % 3 == 0 ? OP_PEEK : OP_ADD, pick_event_id(20), pick_event_time(), $urandom());
    steady_send = 1'b0;
  endtask

  // sender goes quiet until everything owed has arrived, then resumes
  task automatic test_quiet_restart();
    wait_for_drain();
    send_op(OP_PEEK, '0, '0, '0);
    send_op(OP_POP,  '0, '0, '0);
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_ADD;
    in_ch.event_id   = '0;
    in_ch.event_time = '0;
    in_ch.event_data = '0;
    out_ch.ready     = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      model_valid[i] = 1'b0;
      model_id[i]    = '0;
      model_time[i]  = '0;
      model_data[i]  = '0;
    end
    model_count = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix(180);
    test_output_backpressure();
    test_quiet_restart();
    test_random_mix(180);
    test_fill_and_drain();

    // everything sent: wait for the owed results, then let the pipe settle
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
